>>> hw/rtl/imu_calibration_scaler_unit_defines.svh
// Assertion macros shared by the calibration scaler RTL.
`ifndef IMU_CALIBRATION_SCALER_UNIT_DEFINES_SVH
`define IMU_CALIBRATION_SCALER_UNIT_DEFINES_SVH

// Overlapping implication, checked on every rising clock edge outside reset.
`define IMUCS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IMUCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/imucs_pkg.sv
// Package with widths, codes and default constants of the calibration scaler.
`timescale 1ns / 1ps

package imucs_pkg;

   // Field and state widths.
   localparam int unsigned AXES     = 3;
   localparam int unsigned AXIS_W   = 2;
   localparam int unsigned KIND_W   = 2;
   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned NUM_W    = 28;
   localparam int unsigned DEN_W    = 18;
   localparam int unsigned NMAG_W   = 27;
   localparam int unsigned DMAG_W   = 17;
   localparam int unsigned PROD_W   = NMAG_W + SAMPLE_W;
   localparam int unsigned RESULT_W = 32;
   localparam int unsigned CNT_W    = $clog2(PROD_W + 1);
   localparam int unsigned STATE_W  = 2;

   // Stream widths.
   localparam int unsigned REQ_TDATA_W = 96;
   localparam int unsigned REQ_TUSER_W = 4;
   localparam int unsigned RSP_TDATA_W = 32;
   localparam int unsigned RSP_TUSER_W = 5;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_GYRO_CAL    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ACCEL_CAL   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GYRO_SAMPLE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_ACCEL_SAMPLE = 2'd3;

   // Sensor constants.
   localparam int ACC_RES_PER_G    = 8192;
   localparam int GYRO_RES_PER_DPS = 1024;
   localparam int GYRO_SPAN        = 2048;
   localparam int ACC_SPAN_G       = 4;
   localparam int DEFAULT_DENOM    = 32767;
   localparam int GYRO_RES_SHIFT   = $clog2(GYRO_RES_PER_DPS);

   typedef logic signed [NUM_W-1:0] numer_type;
   typedef logic signed [DEN_W-1:0] denom_type;

   localparam numer_type GYRO_NUM_DEFAULT  = NUM_W'(GYRO_SPAN * GYRO_RES_PER_DPS);
   localparam numer_type ACCEL_NUM_DEFAULT = NUM_W'(ACC_SPAN_G * ACC_RES_PER_G);
   localparam numer_type ACCEL_NUM_CAL     = NUM_W'(2 * ACC_RES_PER_G);
   localparam denom_type DEN_DEFAULT       = DEN_W'(DEFAULT_DENOM);

endpackage

>>> hw/rtl/imu_calibration_scaler_unit.sv
// Top level of the gyro and accel calibration scaler.
`timescale 1ns / 1ps

// Per-axis sensitivity scaler for gyro and accel readings. A calibration request
// loads the numerator/denominator pair of one axis (a zero denominator loads the
// default pair and sets the fallback flag) and answers with a zero value. A sample
// request returns numer*raw/denom, truncated toward zero and saturated to 32 bits.
// Requests are taken one at a time. A calibration request goes from IDLE straight to
// DONE, which loads the result. A sample goes from IDLE, which latches the magnitudes,
// to MUL for the bit-serial multiply of the numerator by the raw magnitude, to DIV
// for the restoring divide (one 18-bit subtract and compare per quotient bit) and to
// DONE to saturate into the result register; DONE waits while that register is full.
// The next request is taken in IDLE after DONE. A result waits in the output
// register until the result transfer, while the block takes and works on the next request.
module imu_calibration_scaler_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // cal_plus, cal_minus, cal_bias, speed_plus, speed_minus, raw_sample
   input  logic [imucs_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // req_type, axis
   input  logic [imucs_pkg::REQ_TUSER_W-1:0]  req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // scaled_value
   output logic [imucs_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // axis_echo, kind_echo, fallback_used
   output logic [imucs_pkg::RSP_TUSER_W-1:0]  rsp_tuser
);
   import imucs_pkg::*;

   `include "imu_calibration_scaler_unit_defines.svh"

   localparam logic [STATE_W-1:0] ST_IDLE = 2'd0;
   localparam logic [STATE_W-1:0] ST_MUL  = 2'd1;
   localparam logic [STATE_W-1:0] ST_DIV  = 2'd2;
   localparam logic [STATE_W-1:0] ST_DONE = 2'd3;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(SAMPLE_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

   // Request fields.
   logic [KIND_W-1:0]          kind;
   logic [AXIS_W-1:0]          axis;
   logic signed [SAMPLE_W-1:0] cal_plus;
   logic signed [SAMPLE_W-1:0] cal_minus;
   logic signed [SAMPLE_W-1:0] cal_bias;
   logic signed [SAMPLE_W-1:0] speed_plus;
   logic signed [SAMPLE_W-1:0] speed_minus;
   logic signed [SAMPLE_W-1:0] raw_sample;

   assign kind        = req_tuser[1:0];
   assign axis        = req_tuser[3:2];
   assign cal_plus    = $signed(req_tdata[15:0]);
   assign cal_minus   = $signed(req_tdata[31:16]);
   assign cal_bias    = $signed(req_tdata[47:32]);
   assign speed_plus  = $signed(req_tdata[63:48]);
   assign speed_minus = $signed(req_tdata[79:64]);
   assign raw_sample  = $signed(req_tdata[95:80]);

   // Registers.
   logic [STATE_W-1:0]  state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0] mplier_ff, mplier_in;
   logic [NMAG_W-1:0]   n_mag_ff, n_mag_in;
   logic [DMAG_W-1:0]   d_mag_ff, d_mag_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [DMAG_W-1:0]   rem_ff, rem_in;
   logic                neg_ff, neg_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [AXIS_W-1:0]   axis_ff, axis_in;
   logic                fb_ff, fb_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;
   numer_type gyro_num_ff [AXES];
   numer_type gyro_num_in [AXES];
   denom_type gyro_den_ff [AXES];
   denom_type gyro_den_in [AXES];
   numer_type accel_num_ff [AXES];
   numer_type accel_num_in [AXES];
   denom_type accel_den_ff [AXES];
   denom_type accel_den_in [AXES];

   logic req_fire;
   logic axis_ok;
   logic [AXIS_W-1:0] axis_idx;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign axis_ok    = (axis < AXIS_W'(AXES));
   assign axis_idx   = axis_ok ? axis : '0;

   // Calibration terms: gyro bias-relative spans and reference speed sum, and the accel span.
   logic signed [SAMPLE_W:0] plus_off;
   logic signed [SAMPLE_W:0] minus_off;
   logic signed [SAMPLE_W:0] plus_off_neg;
   logic signed [SAMPLE_W:0] minus_off_neg;
   logic [SAMPLE_W-1:0]      plus_abs;
   logic [SAMPLE_W-1:0]      minus_abs;
   logic [DMAG_W-1:0]        gyro_den_sum;
   logic signed [SAMPLE_W:0] speed_sum;
   numer_type                gyro_num_cal;
   logic signed [SAMPLE_W:0] accel_den_cal;

   assign plus_off      = {cal_plus[SAMPLE_W-1], cal_plus} - {cal_bias[SAMPLE_W-1], cal_bias};
   assign minus_off     = {cal_minus[SAMPLE_W-1], cal_minus} - {cal_bias[SAMPLE_W-1], cal_bias};
   assign plus_off_neg  = -plus_off;
   assign minus_off_neg = -minus_off;
   assign plus_abs      = plus_off[SAMPLE_W] ? plus_off_neg[SAMPLE_W-1:0]
                                             : plus_off[SAMPLE_W-1:0];
   assign minus_abs     = minus_off[SAMPLE_W] ? minus_off_neg[SAMPLE_W-1:0]
                                              : minus_off[SAMPLE_W-1:0];
   assign gyro_den_sum  = {1'b0, plus_abs} + {1'b0, minus_abs};
   assign speed_sum     = {speed_plus[SAMPLE_W-1], speed_plus}
                        + {speed_minus[SAMPLE_W-1], speed_minus};
   assign gyro_num_cal  = {{(NUM_W - SAMPLE_W - 1 - GYRO_RES_SHIFT){speed_sum[SAMPLE_W]}},
                           speed_sum, {GYRO_RES_SHIFT{1'b0}}};
   assign accel_den_cal = {cal_plus[SAMPLE_W-1], cal_plus}
                        - {cal_minus[SAMPLE_W-1], cal_minus};

   // Sample operands: magnitudes and the common sign of the quotient and remainder terms.
   numer_type           sel_num;
   denom_type           sel_den;
   numer_type           sel_num_neg;
   denom_type           sel_den_neg;
   logic signed [SAMPLE_W-1:0] raw_neg;
   logic [NMAG_W-1:0]   sel_n_mag;
   logic [DMAG_W-1:0]   sel_d_mag;
   logic [SAMPLE_W-1:0] sel_r_mag;

   assign sel_num     = (kind == KIND_GYRO_SAMPLE) ? gyro_num_ff[axis_idx]
                                                   : accel_num_ff[axis_idx];
   assign sel_den     = (kind == KIND_GYRO_SAMPLE) ? gyro_den_ff[axis_idx]
                                                   : accel_den_ff[axis_idx];
   assign sel_num_neg = -sel_num;
   assign sel_den_neg = -sel_den;
   assign raw_neg     = -raw_sample;
   assign sel_n_mag   = sel_num[NUM_W-1] ? sel_num_neg[NMAG_W-1:0] : sel_num[NMAG_W-1:0];
   assign sel_d_mag   = sel_den[DEN_W-1] ? sel_den_neg[DMAG_W-1:0] : sel_den[DMAG_W-1:0];
   assign sel_r_mag   = raw_sample[SAMPLE_W-1] ? raw_neg : raw_sample;

   // Restoring divide step.
   logic [DMAG_W:0] trial;
   logic [DMAG_W:0] trial_diff;
   logic            trial_fits;

   assign trial      = {rem_ff, prod_ff[PROD_W-1]};
   assign trial_diff = trial - {1'b0, d_mag_ff};
   assign trial_fits = (trial >= {1'b0, d_mag_ff});

   // Saturation of the signed quotient to the result width.
   logic [RESULT_W-1:0] prod_neg;
   logic                pos_over;
   logic                neg_over;
   logic [RESULT_W-1:0] sat_value;

   assign prod_neg = ~prod_ff[RESULT_W-1:0] + RESULT_W'(1);
   assign pos_over = |prod_ff[PROD_W-1:RESULT_W-1];
   assign neg_over = (|prod_ff[PROD_W-1:RESULT_W])
                  || (prod_ff[RESULT_W-1] && (|prod_ff[RESULT_W-2:0]));

   always_comb begin
      if (neg_ff) begin
         sat_value = neg_over ? {1'b1, {(RESULT_W-1){1'b0}}} : prod_neg;
      end else begin
         sat_value = pos_over ? {1'b0, {(RESULT_W-1){1'b1}}} : prod_ff[RESULT_W-1:0];
      end
   end

   // Sequencer and next-state logic.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mplier_in    = mplier_ff;
      n_mag_in     = n_mag_ff;
      d_mag_in     = d_mag_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      kind_in      = kind_ff;
      axis_in      = axis_ff;
      fb_in        = fb_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      gyro_num_in  = gyro_num_ff;
      gyro_den_in  = gyro_den_ff;
      accel_num_in = accel_num_ff;
      accel_den_in = accel_den_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               kind_in  = kind;
               axis_in  = axis;
               fb_in    = 1'b0;
               prod_in  = '0;
               neg_in   = 1'b0;
               state_in = ST_DONE;
               case (kind)
                  KIND_GYRO_CAL: begin
                     if (axis_ok) begin
                        if (gyro_den_sum == '0) begin
                           gyro_num_in[axis_idx] = GYRO_NUM_DEFAULT;
                           gyro_den_in[axis_idx] = DEN_DEFAULT;
                           fb_in = 1'b1;
                        end else begin
                           gyro_num_in[axis_idx] = gyro_num_cal;
                           gyro_den_in[axis_idx] = {1'b0, gyro_den_sum};
                        end
                     end
                  end
                  KIND_ACCEL_CAL: begin
                     if (axis_ok) begin
                        if (accel_den_cal == '0) begin
                           accel_num_in[axis_idx] = ACCEL_NUM_DEFAULT;
                           accel_den_in[axis_idx] = DEN_DEFAULT;
                           fb_in = 1'b1;
                        end else begin
                           accel_num_in[axis_idx] = ACCEL_NUM_CAL;
                           accel_den_in[axis_idx] = {accel_den_cal[SAMPLE_W], accel_den_cal};
                        end
                     end
                  end
                  default: begin
                     // Samples with a valid axis and nonzero divisor start the multiply.
                     if (axis_ok && (sel_d_mag != '0)) begin
                        n_mag_in  = sel_n_mag;
                        d_mag_in  = sel_d_mag;
                        mplier_in = sel_r_mag;
                        neg_in    = sel_num[NUM_W-1] ^ sel_den[DEN_W-1]
                                  ^ raw_sample[SAMPLE_W-1];
                        cnt_in    = MUL_LAST;
                        state_in  = ST_MUL;
                     end
                  end
               endcase
            end
         end
         ST_MUL: begin
            // One multiplier bit per cycle, most significant first.
            prod_in   = {prod_ff[PROD_W-2:0], 1'b0}
                      + (mplier_ff[SAMPLE_W-1] ? PROD_W'(n_mag_ff) : '0);
            mplier_in = {mplier_ff[SAMPLE_W-2:0], 1'b0};
            cnt_in    = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = DIV_LAST;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // One quotient bit per cycle shifts in where the dividend shifts out.
            rem_in  = trial_fits ? trial_diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
            prod_in = {prod_ff[PROD_W-2:0], trial_fits};
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Load the result register once it is free or being emptied.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_value;
               rsp_user_in  = {fb_ff, kind_ff, axis_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers and per-axis calibration state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            gyro_num_ff[i]  <= GYRO_NUM_DEFAULT;
            gyro_den_ff[i]  <= DEN_DEFAULT;
            accel_num_ff[i] <= ACCEL_NUM_DEFAULT;
            accel_den_ff[i] <= DEN_DEFAULT;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gyro_num_ff  <= gyro_num_in;
         gyro_den_ff  <= gyro_den_in;
         accel_num_ff <= accel_num_in;
         accel_den_ff <= accel_den_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      mplier_ff   <= mplier_in;
      n_mag_ff    <= n_mag_in;
      d_mag_ff    <= d_mag_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      neg_ff      <= neg_in;
      kind_ff     <= kind_in;
      axis_ff     <= axis_in;
      fb_ff       <= fb_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Checks on the sequencer and the stored calibration.
   `IMUCS_ASSERT_NEXT(a_cal_den_nonzero,
      req_fire && axis_ok && ((kind == KIND_GYRO_CAL) || (kind == KIND_ACCEL_CAL)),
      (gyro_den_ff[axis_ff] != '0) && (accel_den_ff[axis_ff] != '0),
      "calibration left a zero denominator")
   `IMUCS_ASSERT_NEXT(a_div_rem_below_divisor, state_ff == ST_DIV, rem_ff < d_mag_ff,
      "divider remainder not below divisor")
   `IMUCS_ASSERT_NEXT(a_done_holds_when_blocked,
      (state_ff == ST_DONE) && rsp_valid_ff && !rsp_tready,
      (state_ff == ST_DONE) && !req_tready,
      "finished item left the sequencer while the result register was full")

endmodule
